### sv/rrts_pkg.sv
`default_nettype none
package rrts_pkg;

  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;
  localparam int FPID_W   = 16;
  localparam int SLICE_W  = 8;

  // Slice length after reset.
  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_CREATE = 2'd1,
    ACT_SWITCH = 2'd2,
    ACT_REMOVE = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NO_SWITCH = 3'd0,
    ST_SWITCHED  = 3'd1,
    ST_CREATED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_REFUSED   = 3'd5
  } status_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [FPID_W-1:0]   target_pid;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FPID_W-1:0]   result_pid;
    logic [FPID_W-1:0]   running_pid;
    logic [SLICE_W-1:0]  slice_left;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_APPLY,
    S_OUT
  } fsm_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic decode;
    logic walk;
    logic apply;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic walk_needed;
    logic walk_done;
  } dp_stat_t;

endpackage
`default_nettype wire

### sv/rrts_ctrl.sv
`default_nettype none
module rrts_ctrl
  import rrts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: state_nxt = stat.walk_needed ? S_WALK : S_APPLY;
      S_WALK:   if (stat.walk_done) state_nxt = S_APPLY;
      S_APPLY:  state_nxt = S_OUT;
      S_OUT:    if (!out_stall) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall   = (state_r != S_IDLE);
    out_valid  = (state_r == S_OUT);
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.decode = (state_r == S_DECODE);
    cmd.walk   = (state_r == S_WALK);
    cmd.apply  = (state_r == S_APPLY);
  end

endmodule
`default_nettype wire

### sv/rrts_dp.sv
`default_nettype none
module rrts_dp
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int PID_WIDTH = 16
)(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire in_beat_t           in_data,
  input  wire logic [SLICE_W-1:0] tsl,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  output out_beat_t               out_data
);

  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = SW + 1;

  logic [MAX_TASKS-1:0] used_r;
  logic [MAX_TASKS-1:0] runst_r;
  logic [PID_WIDTH-1:0] pid_r   [MAX_TASKS];
  logic [SLICE_W-1:0]   slice_r [MAX_TASKS];
  logic [SW-1:0]        next_r  [MAX_TASKS];
  logic [SW-1:0]        prev_r  [MAX_TASKS];
  logic [SW-1:0]        head_r, run_r;
  logic [PID_WIDTH:0]   pidc_r;

  action_t              act_r;
  logic [FPID_W-1:0]    tgt_r;
  logic [SW-1:0]        cur_r;
  logic [CW-1:0]        cnt_r;
  logic                 found_r;
  logic [SW-1:0]        hit_r;
  logic                 expire_r;
  logic [SW-1:0]        free_r;
  logic                 free_ok_r;
  out_beat_t            res_r;
  out_beat_t            res_nxt;

  // Target pid, zero-extended or truncated to the pid width.
  logic [PID_WIDTH-1:0] tgt_w;
  always_comb begin
    tgt_w = '0;
    for (int b = 0; b < PID_WIDTH && b < FPID_W; b++) tgt_w[b] = tgt_r[b];
  end

  function automatic logic [FPID_W-1:0] to_f(input logic [PID_WIDTH-1:0] p);
    logic [FPID_W-1:0] f;
    f = '0;
    for (int b = 0; b < PID_WIDTH && b < FPID_W; b++) f[b] = p[b];
    return f;
  endfunction

  // Lowest free slot by priority encoder.
  logic [SW-1:0] free_w;
  logic          free_any_w;
  always_comb begin
    free_w = '0;
    free_any_w = 1'b0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_w = SW'(i);
        free_any_w = 1'b1;
      end
    end
  end

  // Match test on the slot under the walk pointer.
  logic cur_hit_w;
  always_comb begin
    case (act_r)
      ACT_TICK:   cur_hit_w = used_r[cur_r] && !runst_r[cur_r];
      ACT_SWITCH: cur_hit_w = used_r[cur_r] && (pid_r[cur_r] == tgt_w) && !runst_r[cur_r];
      ACT_REMOVE: cur_hit_w = used_r[cur_r] && (pid_r[cur_r] == tgt_w);
      default:    cur_hit_w = 1'b0;
    endcase
  end

  // Walk ends on a hit, on wrap back to the running slot (tick) or to the head slot, or on the step limit.
  logic [SW-1:0] step_w;
  assign step_w = next_r[cur_r];
  logic stop_w;
  always_comb begin
    if (act_r == ACT_TICK) begin
      stop_w = (cur_r == run_r) || cur_hit_w || (cnt_r == CW'(MAX_TASKS));
    end else begin
      stop_w = cur_hit_w || (step_w == head_r) || (cnt_r == CW'(MAX_TASKS - 1));
    end
  end

  // A tick walks only when the running slice runs out; the slice is stable until apply.
  assign stat.walk_needed = (act_r == ACT_SWITCH) || (act_r == ACT_REMOVE) ||
                            ((act_r == ACT_TICK) && (slice_r[run_r] <= SLICE_W'(1)));
  assign stat.walk_done   = stop_w;

  // Result beat of the current action.
  always_comb begin
    res_nxt             = '0;
    res_nxt.status      = ST_NO_SWITCH;
    res_nxt.running_pid = to_f(pid_r[run_r]);
    res_nxt.slice_left  = slice_r[run_r];
    case (act_r)
      ACT_TICK: begin
        if (!expire_r) begin
          res_nxt.slice_left = slice_r[run_r] - SLICE_W'(1);
        end else if (found_r) begin
          res_nxt.status      = ST_SWITCHED;
          res_nxt.result_pid  = to_f(pid_r[hit_r]);
          res_nxt.running_pid = to_f(pid_r[hit_r]);
          res_nxt.slice_left  = slice_r[hit_r];
        end else begin
          res_nxt.slice_left = tsl;
        end
      end
      ACT_CREATE: begin
        if (!free_ok_r) begin
          res_nxt.status = ST_FULL;
        end else begin
          res_nxt.status     = ST_CREATED;
          res_nxt.result_pid = to_f(pidc_r[PID_WIDTH-1:0]);
        end
      end
      ACT_SWITCH: begin
        if (!found_r) begin
          res_nxt.status = ST_NOT_FOUND;
        end else begin
          res_nxt.status      = ST_SWITCHED;
          res_nxt.result_pid  = to_f(pid_r[hit_r]);
          res_nxt.running_pid = to_f(pid_r[hit_r]);
          res_nxt.slice_left  = slice_r[hit_r];
        end
      end
      default: begin
        if (!found_r) begin
          res_nxt.status = ST_NOT_FOUND;
        end else if (hit_r == run_r) begin
          res_nxt.status = ST_REFUSED;
        end else begin
          res_nxt.result_pid = to_f(pid_r[hit_r]);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      used_r[0]  <= 1'b1;
      runst_r    <= '0;
      runst_r[0] <= 1'b1;
      pid_r[0]   <= '0;
      slice_r[0] <= SLICE_RESET;
      next_r[0]  <= '0;
      prev_r[0]  <= '0;
      head_r     <= '0;
      run_r      <= '0;
      pidc_r     <= (PID_WIDTH+1)'(1);
    end else begin
      if (cmd.load) begin
        act_r <= action_t'(in_data.action);
        tgt_r <= in_data.target_pid;
      end
      if (cmd.decode) begin
        expire_r  <= (slice_r[run_r] <= SLICE_W'(1));
        free_r    <= free_w;
        free_ok_r <= free_any_w && (pidc_r[PID_WIDTH] == 1'b0);
        found_r   <= 1'b0;
        cnt_r     <= (act_r == ACT_TICK) ? CW'(1) : '0;
        cur_r     <= (act_r == ACT_TICK) ? next_r[run_r] : head_r;
      end
      if (cmd.walk) begin
        if (cur_hit_w && !((act_r == ACT_TICK) && (cur_r == run_r))) begin
          found_r <= 1'b1;
          hit_r   <= cur_r;
        end
        if (!stop_w) begin
          cur_r <= step_w;
          cnt_r <= cnt_r + CW'(1);
        end
      end
      if (cmd.apply) begin
        res_r <= res_nxt;
        case (act_r)
          ACT_TICK: begin
            if (!expire_r) begin
              slice_r[run_r] <= slice_r[run_r] - SLICE_W'(1);
            end else begin
              slice_r[run_r] <= tsl;
              if (found_r) begin
                runst_r[run_r] <= 1'b0;
                runst_r[hit_r] <= 1'b1;
                run_r          <= hit_r;
              end
            end
          end
          ACT_CREATE: begin
            if (free_ok_r) begin
              used_r[free_r]          <= 1'b1;
              runst_r[free_r]         <= 1'b0;
              pid_r[free_r]           <= pidc_r[PID_WIDTH-1:0];
              pidc_r                  <= pidc_r + (PID_WIDTH+1)'(1);
              slice_r[free_r]         <= tsl;
              next_r[free_r]          <= head_r;
              prev_r[free_r]          <= prev_r[head_r];
              next_r[prev_r[head_r]]  <= free_r;
              prev_r[head_r]          <= free_r;
            end
          end
          ACT_SWITCH: begin
            if (found_r) begin
              runst_r[run_r] <= 1'b0;
              runst_r[hit_r] <= 1'b1;
              run_r          <= hit_r;
            end
          end
          default: begin
            if (found_r && (hit_r != run_r)) begin
              next_r[prev_r[hit_r]] <= next_r[hit_r];
              prev_r[next_r[hit_r]] <= prev_r[hit_r];
              if (head_r == hit_r) head_r <= next_r[hit_r];
              used_r[hit_r] <= 1'b0;
            end
          end
        endcase
      end
    end
  end

  assign out_data = res_r;

endmodule
`default_nettype wire

### sv/round_robin_time_slice_scheduler_top.sv
// Path: the input beat is loaded, decoded, optionally walked along the ring slot by slot,
// applied into the registered result beat, and held on the output while out_stall is high.
// Throughput: one beat in flight; in_stall holds off a new beat until the result beat is taken.
// Reset: synchronous active-low rst_n; slot 0 holds running pid 0 with a slice of 10.
`default_nettype none
module round_robin_time_slice_scheduler_top
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int PID_WIDTH = 16
)(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_beat_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_beat_t               out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [SLICE_W-1:0] cfg_data
);

  logic [SLICE_W-1:0] tsl_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Slice length register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsl_r <= SLICE_RESET;
    end else if (cfg_valid) begin
      tsl_r <= cfg_data;
    end
  end

  rrts_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .cmd
  );

  rrts_dp #(.MAX_TASKS(MAX_TASKS), .PID_WIDTH(PID_WIDTH)) u_dp (
    .clk, .rst_n, .in_data, .tsl(tsl_r), .cmd, .stat, .out_data
  );

endmodule
`default_nettype wire
